// ===== sv/pfdg_pkg.sv =====
// ----------------------------------------------------------------------------
// pfdg_pkg
// Shared types and constants for the packet fragment descriptor generator.
// ----------------------------------------------------------------------------
package pfdg_pkg;

	// Field widths
	localparam int LEN_W   = 16;
	localparam int TYPE_W  = 2;
	localparam int SIZE_W  = 14;
	localparam int SEQ_W   = 64;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 5;
	localparam int OVL_W   = 32;

	// Most fragments per packet, smallest usable payload size
	localparam int              MAX_FRAGS    = 16;
	localparam logic [SIZE_W-1:0] MIN_PAYLOAD = SIZE_W'(512);
	localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(1400);

	// Restoring division: one quotient bit per step
	localparam int DIV_STEPS = CNT_W;
	localparam int DSTEP_W   = $clog2(DIV_STEPS);
	// Dividend len + size - 1, and divisor shifted by the top quotient bit
	localparam int NUM_W     = LEN_W + 1;
	localparam int DIVS_W    = SIZE_W + DIV_STEPS - 1;
	localparam int CMP_W     = (NUM_W > DIVS_W) ? NUM_W : DIVS_W;

	// Packed stream widths
	localparam int OUT_DATA_BITS = SEQ_W + IDX_W + CNT_W + LEN_W + SIZE_W;
	localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;
	localparam int OUT_USER_W    = 1 + TYPE_W;

	// Result status codes
	localparam logic STATUS_FRAG = 1'b0;
	localparam logic STATUS_DROP = 1'b1;

	// Packet type codes
	localparam logic [TYPE_W-1:0] PT_NONE     = 2'd0;
	localparam logic [TYPE_W-1:0] PT_INTEREST = 2'd1;
	localparam logic [TYPE_W-1:0] PT_DATA     = 2'd2;
	localparam logic [TYPE_W-1:0] PT_NACK     = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic               capture;   // latch the input transaction
		logic               div_step;  // one restoring division step
		logic               emit;      // load one result into the output register
	} pfdg_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic len_zero;   // incoming packet length is zero
		logic over;       // packet needs more than MAX_FRAGS fragments
		logic last_frag;  // current fragment is the final one
		logic out_free;   // output register can take a result this cycle
	} pfdg_stat_t;

endpackage

// ===== sv/pfdg_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfdg_ctrl
// Controller: accepts a packet, runs the fragment count division, then
// sequences one result per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module pfdg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pfdg_pkg::pfdg_stat_t  stat,
	output pfdg_pkg::pfdg_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                         state_q;
	state_t                         state_d;
	logic [pfdg_pkg::DSTEP_W-1:0]   step_q;

	assign in_ready = (state_q == ST_IDLE);

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.div_step = (state_q == ST_DIV);
		cmd.emit     = (state_q == ST_EMIT) && stat.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !stat.len_zero)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == '0)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free && (stat.over || stat.last_frag))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture)
				step_q <= pfdg_pkg::DSTEP_W'(pfdg_pkg::DIV_STEPS - 1);
			else if (cmd.div_step && step_q != '0)
				step_q <= step_q - 1'b1;
		end
	end

endmodule

// ===== sv/pfdg_dp.sv =====
// ----------------------------------------------------------------------------
// pfdg_dp
// Datapath: payload size register, fragment count divider, fragment walk
// (offset, remaining bytes, sequence counter) and the output register.
// ----------------------------------------------------------------------------
module pfdg_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pfdg_pkg::SIZE_W-1:0]       cfg_wr_data,
	input  logic [pfdg_pkg::LEN_W-1:0]        in_len,
	input  logic [pfdg_pkg::TYPE_W-1:0]       in_type,
	input  pfdg_pkg::pfdg_cmd_t               cmd,
	output pfdg_pkg::pfdg_stat_t              stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pfdg_pkg::OUT_DATA_W-1:0]   out_data,
	output logic [pfdg_pkg::OUT_USER_W-1:0]   out_user,
	output logic                              out_last
);

	localparam int LEN_W  = pfdg_pkg::LEN_W;
	localparam int SIZE_W = pfdg_pkg::SIZE_W;
	localparam int CNT_W  = pfdg_pkg::CNT_W;
	localparam int CMP_W  = pfdg_pkg::CMP_W;

	// Configuration and state
	logic [SIZE_W-1:0]            size_cfg_q;
	logic [pfdg_pkg::SEQ_W-1:0]   seq_q;
	logic [pfdg_pkg::OVL_W-1:0]   ovl_cnt_q;

	// Per packet working registers
	logic [LEN_W-1:0]             len_q;
	logic [pfdg_pkg::TYPE_W-1:0]  type_q;
	logic [SIZE_W-1:0]            size_q;
	logic [pfdg_pkg::NUM_W-1:0]   num_q;
	logic [CNT_W-1:0]             quot_q;
	logic [pfdg_pkg::DSTEP_W-1:0] shift_q;
	logic [CNT_W-1:0]             idx_q;
	logic [LEN_W-1:0]             off_q;
	logic [LEN_W-1:0]             rem_q;

	// Output register
	logic                         out_valid_q;
	logic [pfdg_pkg::OUT_DATA_W-1:0] out_data_q;
	logic [pfdg_pkg::OUT_USER_W-1:0] out_user_q;
	logic                         out_last_q;

	logic [SIZE_W-1:0]            size_eff;
	logic [CMP_W-1:0]             div_sh;
	logic                         div_ge;
	logic [SIZE_W-1:0]            frag_sz;
	logic [pfdg_pkg::SEQ_W-1:0]   seq_nxt;
	logic [LEN_W+4:0]             max_len;

	// Payload size clamped to the minimum
	assign size_eff = (size_cfg_q < pfdg_pkg::MIN_PAYLOAD) ? pfdg_pkg::MIN_PAYLOAD
		: size_cfg_q;

	// Divisor shifted to the current quotient bit
	assign div_sh = CMP_W'(size_q) << shift_q;
	assign div_ge = CMP_W'(num_q) >= div_sh;

	// Over length: len > MAX_FRAGS * size (MAX_FRAGS is a power of two here)
	assign max_len = (LEN_W+5)'(size_q) * (LEN_W+5)'(pfdg_pkg::MAX_FRAGS);

	// Fragment size: the remainder, capped at the payload size
	assign frag_sz = (rem_q < LEN_W'(size_q)) ? rem_q[SIZE_W-1:0] : size_q;
	assign seq_nxt = seq_q + 1'b1;

	// Status to controller
	always_comb begin
		stat           = '0;
		stat.len_zero  = (in_len == '0);
		stat.over      = (LEN_W+5)'(len_q) > max_len;
		stat.last_frag = (rem_q <= LEN_W'(size_q));
		stat.out_free  = !out_valid_q || out_ready;
	end

	// Configuration register and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg_q <= pfdg_pkg::SIZE_RESET;
			seq_q      <= '0;
			ovl_cnt_q  <= '0;
		end else begin
			if (cfg_wr_en)
				size_cfg_q <= cfg_wr_data;
			if (cmd.emit) begin
				if (stat.over) begin
					if (ovl_cnt_q != '1)
						ovl_cnt_q <= ovl_cnt_q + 1'b1;
				end else begin
					seq_q <= seq_nxt;
				end
			end
		end
	end

	// Capture, division steps and fragment walk
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			len_q   <= in_len;
			type_q  <= in_type;
			size_q  <= size_eff;
			num_q   <= pfdg_pkg::NUM_W'(in_len) + pfdg_pkg::NUM_W'(size_eff) - 1'b1;
			quot_q  <= '0;
			shift_q <= pfdg_pkg::DSTEP_W'(pfdg_pkg::DIV_STEPS - 1);
			idx_q   <= '0;
			off_q   <= '0;
			rem_q   <= in_len;
		end else if (cmd.div_step) begin
			if (div_ge)
				num_q <= num_q - div_sh[pfdg_pkg::NUM_W-1:0];
			quot_q <= {quot_q[CNT_W-2:0], div_ge};
			if (shift_q != '0)
				shift_q <= shift_q - 1'b1;
		end else if (cmd.emit) begin
			idx_q <= idx_q + 1'b1;
			off_q <= off_q + LEN_W'(frag_sz);
			rem_q <= rem_q - LEN_W'(frag_sz);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (stat.over) begin
				out_data_q <= '0;
				out_user_q <= {pfdg_pkg::PT_NONE, pfdg_pkg::STATUS_DROP};
				out_last_q <= 1'b1;
			end else begin
				out_data_q <= pfdg_pkg::OUT_DATA_W'({frag_sz, off_q, quot_q,
					idx_q[pfdg_pkg::IDX_W-1:0], seq_nxt});
				out_user_q <= {(idx_q == '0) ? type_q : pfdg_pkg::PT_NONE,
					pfdg_pkg::STATUS_FRAG};
				out_last_q <= stat.last_frag;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;
	assign out_last  = out_last_q;

endmodule

// ===== sv/packet_fragment_descriptor_gen_top.sv =====
// ----------------------------------------------------------------------------
// packet_fragment_descriptor_gen_top
// Splits a packet into fragment descriptors, or one drop result when over length.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                                Contents
// s_        in   s_tvalid s_tready s_tdata s_tuser       packet length, type
// m_        out  m_tvalid m_tready m_tdata m_tuser m_tlast  fragment descriptor
// cfg_      in   cfg_wr_en cfg_wr_data                   payload size per fragment
//
// A packet is captured, the divider works out the fragment count one quotient
// bit per step, then one result goes out per fragment (up to 16), or one for a
// drop. A zero length packet gives no result.
// Reset (arst_n low) sets payload size 1400, sequence and drop counters zero.
// m_tready low holds the output register and stalls the fragment walk; the
// last result may still wait while the next packet is taken.
// ----------------------------------------------------------------------------
module packet_fragment_descriptor_gen_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration
	input  logic                              cfg_wr_en,
	input  logic [pfdg_pkg::SIZE_W-1:0]       cfg_wr_data,
	// Packet input
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pfdg_pkg::LEN_W-1:0]        s_tdata,   // [15:0] pkt_len
	input  logic [pfdg_pkg::TYPE_W-1:0]       s_tuser,   // [1:0] pkt_type
	// Descriptor output
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pfdg_pkg::OUT_DATA_W-1:0]   m_tdata,   // [63:0] seq_num, [67:64] frag_index,
	                                                     // [72:68] frag_count,
	                                                     // [88:73] frag_offset,
	                                                     // [102:89] frag_size, [103] zero
	output logic [pfdg_pkg::OUT_USER_W-1:0]   m_tuser,   // [0] status, [2:1] frag_type
	output logic                              m_tlast
);

	pfdg_pkg::pfdg_cmd_t  cmd;
	pfdg_pkg::pfdg_stat_t stat;

	// Sequencing
	pfdg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic and output register
	pfdg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_len      (s_tdata),
		.in_type     (s_tuser),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_user    (m_tuser),
		.out_last    (m_tlast)
	);

endmodule

// ===== verif/packet_fragment_descriptor_gen_top_tb.sv =====
// ----------------------------------------------------------------------------
// packet_fragment_descriptor_gen_top_tb
// Self-checking bench for the packet fragment descriptor generator.
// A directed table covers reset values, the length extremes, every packet
// type, zero length and over-length drops. Random phases then sweep the
// payload size register from below its floor to its top value. Each packet
// is expanded into fragment descriptors by a local model, and every output
// transaction is checked field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module packet_fragment_descriptor_gen_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Bit positions of the descriptor fields in m_tdata
	localparam int IDX_LSB  = pfdg_pkg::SEQ_W;
	localparam int CNT_LSB  = IDX_LSB + pfdg_pkg::IDX_W;
	localparam int OFF_LSB  = CNT_LSB + pfdg_pkg::CNT_W;
	localparam int SIZE_LSB = OFF_LSB + pfdg_pkg::LEN_W;

	// Run shape
	localparam int DIR_ROWS       = 14;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 38;
	localparam int SETTLE_CYCLES  = 30;    // longer than capture + divide + 16 emits
	localparam int TAIL_CYCLES    = 30;
	localparam int WATCHDOG_LIMIT = 5000;  // far above any stall run at 84% idle

	typedef struct packed {
		logic                            status;
		logic [pfdg_pkg::SEQ_W-1:0]      seq_num;
		logic [pfdg_pkg::IDX_W-1:0]      frag_index;
		logic [pfdg_pkg::CNT_W-1:0]      frag_count;
		logic [pfdg_pkg::LEN_W-1:0]      frag_offset;
		logic [pfdg_pkg::SIZE_W-1:0]     frag_size;
		logic [pfdg_pkg::TYPE_W-1:0]     frag_type;
		logic                            last;
	} frag_desc_t;

	typedef struct packed {
		logic [pfdg_pkg::LEN_W-1:0]  len;
		logic [pfdg_pkg::TYPE_W-1:0] ptype;
		logic                        has_want;
		frag_desc_t                  want;
	} stim_row_t;

	localparam frag_desc_t NO_DESC   = '0;
	localparam frag_desc_t DROP_DESC = {pfdg_pkg::STATUS_DROP, 64'd0, 4'd0, 5'd0, 16'd0,
		14'd0, pfdg_pkg::PT_NONE, 1'b1};

	// Directed packets, run at the reset payload size of 1400
	stim_row_t dir_tab [DIR_ROWS] = '{
		'{16'd1,     pfdg_pkg::PT_INTEREST, 1'b1,
			{pfdg_pkg::STATUS_FRAG, 64'd1, 4'd0, 5'd1, 16'd0, 14'd1,
			pfdg_pkg::PT_INTEREST, 1'b1}},
		'{16'd1400,  pfdg_pkg::PT_NACK,     1'b1,
			{pfdg_pkg::STATUS_FRAG, 64'd2, 4'd0, 5'd1, 16'd0, 14'd1400,
			pfdg_pkg::PT_NACK, 1'b1}},
		'{16'd1401,  pfdg_pkg::PT_DATA,     1'b0, NO_DESC},
		'{16'd0,     pfdg_pkg::PT_DATA,     1'b0, NO_DESC},   // no result
		'{16'd22400, pfdg_pkg::PT_NONE,     1'b0, NO_DESC},   // exactly 16 fragments
		'{16'd22401, pfdg_pkg::PT_INTEREST, 1'b1, DROP_DESC}, // one byte over
		'{16'hFFFF,  pfdg_pkg::PT_NACK,     1'b1, DROP_DESC},
		'{16'd0,     pfdg_pkg::PT_NACK,     1'b0, NO_DESC},
		'{16'd2800,  pfdg_pkg::PT_INTEREST, 1'b0, NO_DESC},
		'{16'hAAAA,  pfdg_pkg::PT_DATA,     1'b1, DROP_DESC},
		'{16'h5555,  pfdg_pkg::PT_INTEREST, 1'b0, NO_DESC},
		'{16'd2,     pfdg_pkg::PT_NONE,     1'b0, NO_DESC},
		'{16'd1399,  pfdg_pkg::PT_NACK,     1'b0, NO_DESC},
		'{16'd21000, pfdg_pkg::PT_DATA,     1'b0, NO_DESC}
	};

	localparam logic [pfdg_pkg::SIZE_W-1:0] PHASE_SIZES [NUM_PHASES] = '{
		14'd512, 14'd9000, 14'd0, 14'd16383, 14'd511, 14'd1400, 14'd4096, 14'd600
	};

	// DUT ports
	logic                                clk         = 1'b0;
	logic                                arst_n      = 1'b0;
	logic                                cfg_wr_en   = 1'b0;
	logic [pfdg_pkg::SIZE_W-1:0]         cfg_wr_data = '0;
	logic                                s_tvalid    = 1'b0;
	logic                                s_tready;
	logic [pfdg_pkg::LEN_W-1:0]          s_tdata     = '0;
	logic [pfdg_pkg::TYPE_W-1:0]         s_tuser     = '0;
	logic                                m_tvalid;
	logic                                m_tready    = 1'b0;
	logic [pfdg_pkg::OUT_DATA_W-1:0]     m_tdata;
	logic [pfdg_pkg::OUT_USER_W-1:0]     m_tuser;
	logic                                m_tlast;

	// Model state
	logic [pfdg_pkg::SIZE_W-1:0] model_payload_size = pfdg_pkg::SIZE_RESET;
	logic [pfdg_pkg::SEQ_W-1:0]  model_last_seq     = '0;
	logic [pfdg_pkg::OVL_W-1:0]  model_drop_count   = '0;

	frag_desc_t  pending_descs [$];
	frag_desc_t  seen_desc;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned fail_count    = 0;
	int unsigned pkts_sent     = 0;
	int unsigned descs_seen    = 0;
	int unsigned drops_seen    = 0;
	int unsigned quiet_cycles  = 0;

	packet_fragment_descriptor_gen_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Unpack the output transaction
	assign seen_desc = {m_tuser[0], m_tdata[pfdg_pkg::SEQ_W-1:0],
		m_tdata[IDX_LSB +: pfdg_pkg::IDX_W], m_tdata[CNT_LSB +: pfdg_pkg::CNT_W],
		m_tdata[OFF_LSB +: pfdg_pkg::LEN_W], m_tdata[SIZE_LSB +: pfdg_pkg::SIZE_W],
		m_tuser[1 +: pfdg_pkg::TYPE_W], m_tlast};

	// Payload size actually used: anything below the floor counts as the floor
	function automatic int unsigned eff_payload_size();
		return (model_payload_size < pfdg_pkg::MIN_PAYLOAD) ? int'(pfdg_pkg::MIN_PAYLOAD)
			: int'(model_payload_size);
	endfunction

	// Split one packet into descriptors and queue them; returns how many
	function automatic int unsigned fragment_packet(input logic [pfdg_pkg::LEN_W-1:0] len,
			input logic [pfdg_pkg::TYPE_W-1:0] ptype);
		int unsigned eff, count, off, fsize, i;
		frag_desc_t d;
		eff = eff_payload_size();
		if (len == 0)
			return 0;
		count = (int'(len) + eff - 1) / eff;
		if (count > pfdg_pkg::MAX_FRAGS) begin
			if (model_drop_count != '1)
				model_drop_count++;
			pending_descs.push_back(DROP_DESC);
			return 1;
		end
		off = 0;
		for (i = 0; i < count; i++) begin
			fsize = (int'(len) - off < eff) ? int'(len) - off : eff;
			model_last_seq = model_last_seq + 1'b1;
			d.status      = pfdg_pkg::STATUS_FRAG;
			d.seq_num     = model_last_seq;
			d.frag_index  = pfdg_pkg::IDX_W'(i);
			d.frag_count  = pfdg_pkg::CNT_W'(count);
			d.frag_offset = pfdg_pkg::LEN_W'(off);
			d.frag_size   = pfdg_pkg::SIZE_W'(fsize);
			d.frag_type   = (i == 0) ? ptype : pfdg_pkg::PT_NONE;
			d.last        = (i + 1 == count);
			pending_descs.push_back(d);
			off += fsize;
		end
		return count;
	endfunction

	// Packet length biased toward every fragment count and its boundaries
	function automatic logic [pfdg_pkg::LEN_W-1:0] pick_len(input int unsigned eff);
		int unsigned roll, k, kmax, lo, hi;
		roll = $urandom_range(0, 99);
		kmax = 65534 / eff + 1;
		if (kmax > pfdg_pkg::MAX_FRAGS)
			kmax = pfdg_pkg::MAX_FRAGS;
		if (roll < 5)
			return '0;
		if (roll < 15)
			return pfdg_pkg::LEN_W'($urandom);
		if (roll < 25 && pfdg_pkg::MAX_FRAGS * eff < 65535)
			return pfdg_pkg::LEN_W'($urandom_range(pfdg_pkg::MAX_FRAGS * eff + 1, 65535));
		k  = $urandom_range(1, kmax);
		lo = (k - 1) * eff + 1;
		hi = k * eff;
		if (hi > 65535)
			hi = 65535;
		case ($urandom_range(0, 4))
			0: return pfdg_pkg::LEN_W'(lo);
			1: return pfdg_pkg::LEN_W'(hi);
			default: return pfdg_pkg::LEN_W'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Present one packet and return at the edge where it is accepted
	task automatic send_packet(input logic [pfdg_pkg::LEN_W-1:0] len,
			input logic [pfdg_pkg::TYPE_W-1:0] ptype);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= len;
		s_tuser  <= ptype;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pkts_sent++;
	endtask

	// Hold off the input until every queued descriptor has come out
	task automatic drain_descs();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_descs.size() != 0);
	endtask

	// Register write, only with the block idle
	task automatic set_payload_size(input logic [pfdg_pkg::SIZE_W-1:0] value);
		drain_descs();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_payload_size = value;
	endtask

	// Receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Output checker
	always @(posedge clk) begin
		frag_desc_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_descs.size() == 0) begin
				$display("%0t: unexpected descriptor, expected none, actual %h", $time, seen_desc);
				fail_count++;
			end else begin
				want = pending_descs.pop_front();
				check_field("status", want.status, seen_desc.status);
				check_field("seq_num", want.seq_num, seen_desc.seq_num);
				check_field("frag_index", want.frag_index, seen_desc.frag_index);
				check_field("frag_count", want.frag_count, seen_desc.frag_count);
				check_field("frag_offset", want.frag_offset, seen_desc.frag_offset);
				check_field("frag_size", want.frag_size, seen_desc.frag_size);
				check_field("frag_type", want.frag_type, seen_desc.frag_type);
				check_field("last", want.last, seen_desc.last);
				descs_seen++;
				if (want.status == pfdg_pkg::STATUS_DROP)
					drops_seen++;
			end
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d descriptors outstanding",
				$time, WATCHDOG_LIMIT, pending_descs.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus
	initial begin
		logic [pfdg_pkg::LEN_W-1:0]  len;
		logic [pfdg_pkg::TYPE_W-1:0] ptype;
		int unsigned                 n, sent;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset payload size
		send_idle_pct = 14;
		recv_idle_pct = 84;
		for (int r = 0; r < DIR_ROWS; r++) begin
			send_packet(dir_tab[r].len, dir_tab[r].ptype);
			n = fragment_packet(dir_tab[r].len, dir_tab[r].ptype);
			if (dir_tab[r].has_want && n == 1)
				pending_descs[pending_descs.size() - 1] = dir_tab[r].want;
			if (r == 6)
				drain_descs();
		end

		// Random phases, one payload size each
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 3) begin
				send_idle_pct = 84;
				recv_idle_pct = 14;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_payload_size((p == NUM_PHASES - 1)
				? pfdg_pkg::SIZE_W'($urandom_range(512, 9000)) : PHASE_SIZES[p]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len   = pick_len(eff_payload_size());
				ptype = pfdg_pkg::TYPE_W'($urandom);
				send_packet(len, ptype);
				void'(fragment_packet(len, ptype));
				if (len != 0)
					sent++;
				if ($urandom_range(0, 99) < 3)
					drain_descs();
			end
		end

		drain_descs();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_descs.size() != 0) begin
			$display("%0t: %0d descriptors never arrived", $time, pending_descs.size());
			fail_count++;
		end

		$display("Sent %0d packets over %0d payload sizes (floor, top, below floor, max width).",
			pkts_sent, NUM_PHASES + 1);
		$display("Checked %0d descriptors, %0d of them drops; %0d field mismatches.",
			descs_seen, drops_seen, fail_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/pfdg_pkg.sv
sv/pfdg_ctrl.sv
sv/pfdg_dp.sv
sv/packet_fragment_descriptor_gen_top.sv
verif/packet_fragment_descriptor_gen_top_tb.sv
